@@ rtl/core/rrip_pkg.sv @@
// Shared constants, types and codes for the RRIP replacement engine.
package rrip_pkg;

  localparam int NUM_SETS        = 2048;
  localparam int NUM_WAYS        = 16;
  localparam int HASH_INDEX_BITS = 10;
  localparam int DUEL_GROUP_SETS = 64;

  localparam int SET_BITS   = $clog2(NUM_SETS);
  localparam int WAY_BITS   = $clog2(NUM_WAYS);
  localparam int ROW_BITS   = 2 * NUM_WAYS;
  localparam int HASH_SIZE  = 1 << HASH_INDEX_BITS;
  localparam int DUEL_BITS  = $clog2(DUEL_GROUP_SETS);
  localparam int LINE_BITS  = 42;
  localparam int LINE_SHIFT = 6;
  localparam int CLR_LEN    = (NUM_SETS > HASH_SIZE) ? NUM_SETS : HASH_SIZE;
  localparam int CLR_BITS   = $clog2(CLR_LEN);

  localparam logic [1:0] RRPV_MAX     = 2'd3;
  localparam logic [1:0] SIG_MAX      = 2'd3;
  localparam logic [1:0] SIG_RESET    = 2'd1;
  localparam logic [1:0] THR_RESET    = 2'd2;
  localparam logic [9:0] SEL_MAX      = 10'd1023;
  localparam logic [9:0] SEL_MID      = 10'd511;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic [1:0]           sig;
    logic [1:0]           cnt;
    logic [LINE_BITS-1:0] last;
  } hent_t;

endpackage

@@ rtl/core/rrip_ship_dueling_replacement.sv @@
// RRIP replacement engine: per-set RRPV rows, signature/stream table and duel selector.
//
// For each request the set row and the PC-hash table entry are read from
// their synchronous memories in the accept cycle, and ST_BUSY computes the victim or the update
// and writes the row back, plus the hash entry for an update. A find-victim request also waits
// there while the previous victim is still stalled at the output. After reset a clearing pass
// over CLR_LEN addresses initializes both memories; no request is taken during it. The
// stream threshold register may be written at any time and is used by the next update.
module rrip_ship_dueling_replacement (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        acc_valid,
  output logic        acc_stall,
  input  logic        operation,
  input  logic [10:0] set_index,
  input  logic [3:0]  way_index,
  input  logic [47:0] pc,
  input  logic [47:0] phys_addr,
  input  logic        was_hit,
  output logic        vic_valid,
  input  logic        vic_stall,
  output logic [3:0]  victim_way
);
  import rrip_pkg::*;

  state_t state, state_next;
  logic [CLR_BITS-1:0] clr_idx;
  logic [1:0]          thr;
  logic [9:0]          sel;

  logic [ROW_BITS-1:0] row_mem [NUM_SETS];
  hent_t               hash_mem [HASH_SIZE];
  logic [ROW_BITS-1:0] row_rdata;
  hent_t               hash_rdata;

  // request held for the compute cycle
  op_t                    r_op;
  logic [SET_BITS-1:0]    r_set;
  logic [WAY_BITS-1:0]    r_way;
  logic [HASH_INDEX_BITS-1:0] r_hidx;
  logic                   r_fallback;
  logic [LINE_BITS-1:0]   r_line;
  logic                   r_hit;

  logic accept, clearing, finish;
  logic [HASH_INDEX_BITS-1:0] acc_hidx;
  logic [47:0] acc_hash;

  // victim path
  logic [1:0]          top;
  logic [WAY_BITS-1:0] first;
  logic [ROW_BITS-1:0] aged_row;

  // update path
  logic                step;
  logic [1:0]          cnt_new, sig_new, ins;
  logic [9:0]          sel_new;
  logic                way_ok;
  logic [ROW_BITS-1:0] upd_row;
  hent_t               hent_new;

  logic                row_we;
  logic [SET_BITS-1:0] row_waddr;
  logic [ROW_BITS-1:0] row_wdata;
  logic                hash_we;
  logic [HASH_INDEX_BITS-1:0] hash_waddr;
  hent_t               hash_wdata;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == CLR_BITS'(CLR_LEN - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (acc_valid) state_next = ST_BUSY;
      ST_BUSY:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // FSM outputs
  always_comb begin
    acc_stall = 1'b1;
    clearing  = 1'b0;
    finish    = 1'b0;
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  acc_stall = 1'b0;
      ST_BUSY:  finish = (r_op == OP_UPDATE) || !vic_valid || !vic_stall;
      default:  clearing = 1'b0;
    endcase
  end

  assign accept   = acc_valid && !acc_stall;
  assign acc_hash = pc ^ (pc >> 13) ^ (pc >> 23);
  assign acc_hidx = acc_hash[HASH_INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      thr     <= THR_RESET;
      sel     <= SEL_MID;
    end else begin
      state <= state_next;
      if (clearing) clr_idx <= clr_idx + 1'b1;
      if (cfg_we) thr <= cfg_wdata;
      if (finish && r_op == OP_UPDATE && !r_hit) sel <= sel_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_op       <= op_t'(operation);
      r_set      <= set_index[SET_BITS-1:0];
      r_way      <= way_index[WAY_BITS-1:0];
      r_hidx     <= acc_hidx;
      r_fallback <= (acc_hash[4:0] == 5'd0);
      r_line     <= phys_addr[LINE_SHIFT +: LINE_BITS];
      r_hit      <= was_hit;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (accept) row_rdata <= row_mem[set_index[SET_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hash_we) hash_mem[hash_waddr] <= hash_wdata;
    if (accept) hash_rdata <= hash_mem[acc_hidx];
  end

  // victim selection and aging
  always_comb begin
    top   = 2'd0;
    first = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row_rdata[2*w +: 2] > top) top = row_rdata[2*w +: 2];
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_rdata[2*w +: 2] == top) first = WAY_BITS'(w);
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[2*w +: 2] = row_rdata[2*w +: 2] + (RRPV_MAX - top);
    end
  end

  // update: stream training, signature, duel selector, insertion
  always_comb begin
    step = ({1'b0, r_line} == {1'b0, hash_rdata.last} + 1'b1) ||
           ({1'b0, hash_rdata.last} == {1'b0, r_line} + 1'b1);
    if (!step) cnt_new = 2'd0;
    else if (hash_rdata.cnt < thr) cnt_new = hash_rdata.cnt + 2'd1;
    else cnt_new = hash_rdata.cnt;

    if (!r_set[DUEL_BITS-1]) sel_new = (sel != 10'd0) ? sel - 10'd1 : sel;
    else sel_new = (sel != SEL_MAX) ? sel + 10'd1 : sel;

    sig_new = hash_rdata.sig;
    if (r_hit) begin
      ins = 2'd0;
      if (hash_rdata.sig < SIG_MAX) sig_new = hash_rdata.sig + 2'd1;
    end else if (cnt_new >= thr) begin
      ins = RRPV_MAX;
    end else begin
      if (hash_rdata.sig == SIG_MAX || sel_new > SEL_MID || r_fallback) ins = 2'd0;
      else ins = RRPV_MAX;
      if (hash_rdata.sig != 2'd0) sig_new = hash_rdata.sig - 2'd1;
    end

    hent_new.sig  = sig_new;
    hent_new.cnt  = cnt_new;
    hent_new.last = r_line;

    way_ok  = (32'(r_way) < NUM_WAYS);
    upd_row = row_rdata;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_ok && 32'(r_way) == w) upd_row[2*w +: 2] = ins;
    end
  end

  // write ports: clearing pass or write-back
  always_comb begin
    row_we     = 1'b0;
    row_waddr  = r_set;
    row_wdata  = (r_op == OP_VICTIM) ? aged_row : upd_row;
    hash_we    = 1'b0;
    hash_waddr = r_hidx;
    hash_wdata = hent_new;
    if (clearing) begin
      row_we          = (32'(clr_idx) < NUM_SETS);
      row_waddr       = clr_idx[SET_BITS-1:0];
      row_wdata       = '1;
      hash_we         = (32'(clr_idx) < HASH_SIZE);
      hash_waddr      = clr_idx[HASH_INDEX_BITS-1:0];
      hash_wdata.sig  = SIG_RESET;
      hash_wdata.cnt  = 2'd0;
      hash_wdata.last = '0;
    end else if (finish) begin
      row_we  = 1'b1;
      hash_we = (r_op == OP_UPDATE);
    end
  end

  // victim output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vic_valid <= 1'b0;
    end else if (finish && r_op == OP_VICTIM) begin
      vic_valid <= 1'b1;
    end else if (!vic_stall) begin
      vic_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && r_op == OP_VICTIM) victim_way <= 4'(first);
  end

endmodule
